// ===== rtl/gte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gte_pkg
// Types and codes shared by the graph traversal engine.
// ----------------------------------------------------------------------------
package gte_pkg;

    localparam int VW = 6;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_START = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ORD_REC   = 2'd0,
        ORD_LAZY  = 2'd1,
        ORD_BFS   = 2'd2,
        ORD_BFS3  = 2'd3
    } t_order;

    typedef enum logic [1:0] {
        K_ACCEPT = 2'd0,
        K_REJECT = 2'd1,
        K_CLEAR  = 2'd2,
        K_VISIT  = 2'd3
    } t_kind;

    typedef struct packed {
        t_op          op;
        logic [VW-1:0] from_vertex;
        logic [VW-1:0] to_vertex;
        t_order       order;
    } t_req;

    typedef struct packed {
        t_kind         kind;
        logic [VW-1:0] vertex;
        logic          last;
    } t_rsp;

endpackage
`default_nettype wire

// ===== rtl/graph_traversal_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_traversal_engine
// Adjacency-list graph store with recursive DFS, lazy stack DFS and BFS walks.
// ----------------------------------------------------------------------------
// channel | valid   | ready   | payload
// request | i_valid | o_ready | i_req  (t_req)
// result  | o_valid | i_ready | o_rsp  (t_rsp)
//
// Clear: result registered at the accepting edge. Add edge: degree read at the
// accepting edge, then list append and degree write-back in S_ADD.
// Walk: S_POP, S_TOP, S_DEG per popped stack/queue entry, S_CHK and S_EMIT per list
// entry, S_CHK to close the list, S_NEW per recursive descent, S_FLUSH for the last visit.
// Requests are taken only when idle with the output register empty.
// A result waits in the output register; the walk holds a visit while it is full and not taken.
// ----------------------------------------------------------------------------
module graph_traversal_engine
    import gte_pkg::*;
#(
    parameter int VERTICES   = 64,
    parameter int MAX_DEGREE = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire       i_ready,
    output t_rsp      o_rsp
);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int WD = VERTICES * MAX_DEGREE + 1;
    localparam int WA = $clog2(WD + 1);
    localparam int WI = $clog2(WD);
    localparam int VA = $clog2(VERTICES);
    localparam int NA = $clog2(VERTICES * MAX_DEGREE);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ADD   = 9'b000000010,
        S_POP   = 9'b000000100,
        S_TOP   = 9'b000001000,
        S_DEG   = 9'b000010000,
        S_NEW   = 9'b000100000,
        S_CHK   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_FLUSH = 9'b100000000
    } t_state;

    t_state r_state;

    logic [VW-1:0] nbr_mem  [VERTICES*MAX_DEGREE];
    logic [DW-1:0] deg_mem  [VERTICES];
    logic [DW-1:0] scan_mem [VERTICES];
    logic [VW-1:0] work_mem [WD];

    logic [VW-1:0]       r_nbr_q, r_work_q;
    logic [DW-1:0]       r_deg_q, r_scan_q;
    logic                r_deg_okq;
    logic [VERTICES-1:0] r_deg_ok;
    logic [VERTICES-1:0] r_vis;

    t_req          r_req;
    logic [VW-1:0] r_u;
    logic [DW-1:0] r_i, r_d;
    logic [WA-1:0] r_top, r_head;
    logic          r_have;
    logic [VW-1:0] r_pend;
    logic          r_ov;
    t_rsp          r_rsp;

    logic          nb_re, nb_we, wk_re, wk_we, sc_we;
    logic [NA-1:0] nb_ra, nb_wa;
    logic [VW-1:0] wk_wd;
    logic [WA-1:0] wk_ra, wk_wa;
    logic [VA-1:0] deg_ra, sc_wa;
    logic [DW-1:0] sc_wd;
    logic          rsp_load;
    t_rsp          rsp_d;

    logic          acc;
    logic          out_free;
    logic          start_ok;
    logic          is_bfs;
    logic          walk_empty;
    logic [DW-1:0] deg_now;
    logic          add_ok;
    logic          top_ok;
    logic          nbr_ok;
    logic          emit_ok;

    assign o_valid = r_ov;
    assign o_rsp   = r_rsp;
    assign o_ready = (r_state == S_IDLE) && !r_ov;

    assign acc        = i_valid && o_ready;
    assign out_free   = !r_ov || i_ready;
    assign start_ok   = acc && (i_req.op == OP_START) && (32'(i_req.from_vertex) < VERTICES);
    assign is_bfs     = (r_req.order == ORD_BFS) || (r_req.order == ORD_BFS3);
    assign walk_empty = is_bfs ? (r_head == r_top) : (r_top == '0);
    assign deg_now    = r_deg_okq ? r_deg_q : '0;
    assign add_ok     = (32'(r_req.from_vertex) < VERTICES) &&
                        (32'(r_req.to_vertex) < VERTICES) &&
                        (32'(deg_now) < MAX_DEGREE);
    assign top_ok     = (32'(r_work_q) < VERTICES) && !r_vis[VA'(r_work_q)];
    assign nbr_ok     = (32'(r_nbr_q) < VERTICES) && !r_vis[VA'(r_nbr_q)]
                        && (32'(r_top) < WD);
    assign emit_ok    = !r_have || out_free;

    function automatic logic [NA-1:0] naddr(logic [VW-1:0] v, logic [DW-1:0] i);
        logic [NA-1:0] a;
        a = NA'(VA'(v)) * NA'(MAX_DEGREE) + NA'(i);
        return a;
    endfunction

    always_comb begin
        deg_ra   = VA'(i_req.from_vertex);
        nb_re    = 1'b0;
        nb_ra    = naddr(r_u, r_i);
        nb_we    = 1'b0;
        nb_wa    = naddr(r_req.from_vertex, deg_now);
        wk_re    = 1'b0;
        wk_ra    = is_bfs ? r_head : r_top - WA'(1);
        wk_we    = 1'b0;
        wk_wa    = r_top;
        wk_wd    = r_nbr_q;
        sc_we    = 1'b0;
        sc_wa    = VA'(r_u);
        sc_wd    = r_i;
        rsp_load = 1'b0;
        rsp_d    = '{kind: K_VISIT, vertex: r_pend, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (start_ok) begin
                    wk_we = 1'b1;
                    wk_wa = '0;
                    wk_wd = i_req.from_vertex;
                    sc_we = 1'b1;
                    sc_wa = VA'(i_req.from_vertex);
                    sc_wd = '0;
                end
                if (acc && i_req.op == OP_CLEAR) begin
                    rsp_load = 1'b1;
                    rsp_d    = '{kind: K_CLEAR, vertex: '0, last: 1'b1};
                end
            end
            S_ADD: begin
                nb_we    = add_ok;
                rsp_load = 1'b1;
                rsp_d    = '{kind: add_ok ? K_ACCEPT : K_REJECT, vertex: '0, last: 1'b1};
            end
            S_POP: wk_re = !walk_empty;
            S_TOP: begin
                deg_ra   = VA'(r_work_q);
                rsp_load = (r_req.order == ORD_LAZY) && top_ok && r_have && out_free;
            end
            S_DEG, S_NEW: ;
            S_CHK: nb_re = (r_i < r_d);
            S_EMIT: begin
                deg_ra = VA'(r_nbr_q);
                if (nbr_ok && (r_req.order == ORD_LAZY || emit_ok)) begin
                    wk_we = 1'b1;
                    sc_we = (r_req.order == ORD_REC);
                end
                rsp_load = nbr_ok && (r_req.order != ORD_LAZY) && r_have && out_free;
            end
            S_FLUSH: begin
                rsp_load   = r_have && out_free;
                rsp_d.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (nb_we) nbr_mem[nb_wa] <= r_req.to_vertex;
        if (nb_re) r_nbr_q <= nbr_mem[nb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nb_we) deg_mem[VA'(r_req.from_vertex)] <= deg_now + DW'(1);
        r_deg_q   <= deg_mem[deg_ra];
        r_deg_okq <= r_deg_ok[deg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sc_we) scan_mem[sc_wa] <= sc_wd;
        r_scan_q <= scan_mem[deg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (wk_we) work_mem[wk_wa[WI-1:0]] <= wk_wd;
        if (wk_re) r_work_q <= work_mem[wk_ra[WI-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_rsp <= '{kind: K_ACCEPT, vertex: '0, last: 1'b0};
        end else if (rsp_load) begin
            r_ov  <= 1'b1;
            r_rsp <= rsp_d;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vis    <= '0;
            r_deg_ok <= '0;
            r_have   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_req <= i_req;
                        unique case (i_req.op)
                            OP_ADD:   r_state <= S_ADD;
                            OP_CLEAR: r_deg_ok <= '0;
                            OP_START: begin
                                r_vis  <= (start_ok && i_req.order != ORD_LAZY) ?
                                          (VERTICES'(1) << VA'(i_req.from_vertex)) : '0;
                                r_have <= start_ok && (i_req.order != ORD_LAZY);
                                r_pend <= i_req.from_vertex;
                                r_top  <= start_ok ? WA'(1) : '0;
                                r_head <= '0;
                                if (start_ok) r_state <= S_POP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ADD: begin
                    if (add_ok) r_deg_ok[VA'(r_req.from_vertex)] <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_POP: begin
                    if (walk_empty) begin
                        r_state <= S_FLUSH;
                    end else begin
                        if (is_bfs) r_head <= r_head + WA'(1);
                        else if (r_req.order == ORD_LAZY) r_top <= r_top - WA'(1);
                        r_state <= S_TOP;
                    end
                end
                S_TOP: begin
                    r_u <= r_work_q;
                    if (r_req.order != ORD_LAZY) begin
                        r_state <= S_DEG;
                    end else if (!top_ok) begin
                        r_state <= S_POP;
                    end else if (emit_ok) begin
                        r_have <= 1'b1;
                        r_pend <= r_work_q;
                        r_vis[VA'(r_work_q)] <= 1'b1;
                        r_state <= S_DEG;
                    end
                end
                S_DEG: begin
                    r_d <= deg_now;
                    r_i <= (r_req.order == ORD_REC) ? r_scan_q : '0;
                    r_state <= S_CHK;
                end
                S_NEW: begin
                    r_d <= deg_now;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_i < r_d) begin
                        r_i <= r_i + DW'(1);
                        r_state <= S_EMIT;
                    end else begin
                        if (r_req.order == ORD_REC) r_top <= r_top - WA'(1);
                        r_state <= S_POP;
                    end
                end
                S_EMIT: begin
                    if (!nbr_ok) begin
                        r_state <= S_CHK;
                    end else if (r_req.order == ORD_LAZY) begin
                        r_top <= r_top + WA'(1);
                        r_state <= S_CHK;
                    end else if (emit_ok) begin
                        r_have <= 1'b1;
                        r_pend <= r_nbr_q;
                        r_vis[VA'(r_nbr_q)] <= 1'b1;
                        r_top <= r_top + WA'(1);
                        if (r_req.order == ORD_REC) begin
                            r_u <= r_nbr_q;
                            r_i <= '0;
                            r_state <= S_NEW;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_have) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_have <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("ready during walk");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> $stable(r_rsp))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && !r_have) |=> (r_state == S_IDLE))
        else $error("flush stuck");

endmodule
`default_nettype wire

// ===== verif/tb_graph_traversal_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_traversal_engine
// Drives add-edge, clear, start and no-op requests into the traversal engine with
// random idle gaps on both channels, predicts every result from a local
// graph model and checks each result in order.
// ----------------------------------------------------------------------------
module tb_graph_traversal_engine;
    import gte_pkg::*;

    localparam int NV = 64;
    localparam int MD = 16;
    localparam int WD = NV * MD + 1;
    localparam int N_RAND = 440;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_req i_req = '0;
    logic o_ready;
    logic o_valid;
    t_rsp o_rsp;

    graph_traversal_engine #(.VERTICES(NV), .MAX_DEGREE(MD)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    always #2 i_clk = ~i_clk;

    logic [5:0] adj [NV][MD];
    int         deg [NV];
    bit         seen [NV];
    logic [5:0] work [WD];
    int         scan [NV];
    t_rsp       rsp_q [$];
    int         errors = 0;

    task automatic emit(input t_kind k, input logic [5:0] v);
        t_rsp r;
        r.kind = k;
        r.vertex = v;
        r.last = 1'b0;
        rsp_q.insert(rsp_q.size(), r);
    endtask

    task automatic mark(input logic [5:0] v);
        seen[v] = 1'b1;
        emit(K_VISIT, v);
    endtask

    task automatic predict_walk(input t_req q);
        int top, hd, tl, u, v, s;
        s = q.from_vertex;
        if (s >= NV) return;
        if (q.order == ORD_REC) begin
            top = 0;
            mark(6'(s));
            scan[s] = 0;
            work[top++] = 6'(s);
            while (top > 0) begin
                u = work[top-1];
                if (scan[u] < deg[u]) begin
                    v = adj[u][scan[u]];
                    scan[u]++;
                    if (v < NV && !seen[v] && top < WD) begin
                        mark(6'(v));
                        scan[v] = 0;
                        work[top++] = 6'(v);
                    end
                end else begin
                    top--;
                end
            end
        end else if (q.order == ORD_LAZY) begin
            top = 0;
            work[top++] = 6'(s);
            while (top > 0) begin
                u = work[--top];
                if (u < NV && !seen[u]) begin
                    mark(6'(u));
                    for (int i = 0; i < deg[u]; i++) begin
                        v = adj[u][i];
                        if (v < NV && !seen[v] && top < WD) work[top++] = 6'(v);
                    end
                end
            end
        end else begin
            hd = 0;
            tl = 0;
            mark(6'(s));
            work[tl++] = 6'(s);
            while (hd < tl) begin
                u = work[hd++];
                for (int i = 0; i < deg[u]; i++) begin
                    v = adj[u][i];
                    if (v < NV && !seen[v] && tl < WD) begin
                        mark(6'(v));
                        work[tl++] = 6'(v);
                    end
                end
            end
        end
    endtask

    task automatic predict_graph(input t_req q);
        int n0;
        n0 = rsp_q.size();
        case (q.op)
            OP_ADD: begin
                if (q.from_vertex >= NV || q.to_vertex >= NV || deg[q.from_vertex] >= MD) begin
                    emit(K_REJECT, 6'd0);
                end else begin
                    adj[q.from_vertex][deg[q.from_vertex]] = q.to_vertex;
                    deg[q.from_vertex]++;
                    emit(K_ACCEPT, 6'd0);
                end
            end
            OP_CLEAR: begin
                foreach (deg[i]) deg[i] = 0;
                emit(K_CLEAR, 6'd0);
            end
            OP_START: begin
                foreach (seen[i]) seen[i] = 1'b0;
                predict_walk(q);
            end
            default: ;
        endcase
        if (rsp_q.size() > n0) rsp_q[rsp_q.size()-1].last = 1'b1;
    endtask

    // accepted-result checker with random backpressure
    int stall = 0;
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_valid && i_ready) begin
            if (rsp_q.size() == 0) begin
                $error("unexpected result %p", o_rsp);
                errors++;
            end else begin
                e = rsp_q.pop_front();
                if (o_rsp.kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, o_rsp.kind);
                    errors++;
                end
                if (o_rsp.vertex !== e.vertex) begin
                    $error("vertex exp %0d got %0d", e.vertex, o_rsp.vertex);
                    errors++;
                end
                if (o_rsp.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_rsp.last);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall > 0) begin
            stall--;
            i_ready <= 1'b0;
        end else if (i_ready && o_valid) begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            i_ready <= (stall == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    typedef struct {
        t_req  req;
        bit    chk;
        t_kind kind;
    } t_row;

    task automatic send(input t_req q, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req <= q;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predict_graph(q);
        @(negedge i_clk);
    endtask

    function automatic t_req mk(t_op op, int f, int t, t_order o);
        t_req q;
        q.op = op;
        q.from_vertex = 6'(f);
        q.to_vertex = 6'(t);
        q.order = o;
        return q;
    endfunction

    task automatic drain;
        i_valid <= 1'b0;
        while (rsp_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    t_row rows [$];
    t_req r;
    int k;

    initial begin
        foreach (deg[i]) deg[i] = 0;
        foreach (seen[i]) seen[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        rows.insert(rows.size(), '{mk(OP_START, 0, 0, ORD_REC), 1, K_VISIT});
        rows.insert(rows.size(), '{mk(OP_ADD, 0, 63, ORD_REC), 1, K_ACCEPT});
        rows.insert(rows.size(), '{mk(OP_ADD, 63, 0, ORD_BFS3), 1, K_ACCEPT});
        rows.insert(rows.size(), '{mk(OP_ADD, 0, 1, ORD_REC), 1, K_ACCEPT});
        rows.insert(rows.size(), '{mk(OP_ADD, 1, 2, ORD_REC), 1, K_ACCEPT});
        rows.insert(rows.size(), '{mk(OP_ADD, 0, 2, ORD_REC), 1, K_ACCEPT});
        rows.insert(rows.size(), '{mk(OP_START, 0, 0, ORD_REC), 0, K_VISIT});
        rows.insert(rows.size(), '{mk(OP_START, 0, 0, ORD_LAZY), 0, K_VISIT});
        rows.insert(rows.size(), '{mk(OP_START, 0, 0, ORD_BFS), 0, K_VISIT});
        rows.insert(rows.size(), '{mk(OP_START, 63, 5, ORD_BFS3), 0, K_VISIT});
        rows.insert(rows.size(), '{mk(OP_NONE, 63, 63, ORD_BFS3), 0, K_VISIT});
        for (int i = 0; i < MD - 3; i++)
            rows.insert(rows.size(), '{mk(OP_ADD, 0, i + 3, ORD_REC), 1, K_ACCEPT});
        rows.insert(rows.size(), '{mk(OP_ADD, 0, 40, ORD_REC), 1, K_REJECT});
        rows.insert(rows.size(), '{mk(OP_START, 0, 0, ORD_LAZY), 0, K_VISIT});
        rows.insert(rows.size(), '{mk(OP_CLEAR, 0, 0, ORD_REC), 1, K_CLEAR});
        foreach (rows[i]) begin
            send(rows[i].req, $urandom_range(0, 7));
            if (rows[i].chk) begin
                if (rsp_q.size() == 0 || rsp_q[rsp_q.size()-1].kind != rows[i].kind) begin
                    $error("table row %0d kind exp %0d", i, rows[i].kind);
                    errors++;
                end
            end
        end
        drain();

        k = 0;
        while (k < N_RAND) begin
            if ($urandom_range(0, 29) == 0) begin
                r = mk(OP_CLEAR, $urandom, $urandom, t_order'($urandom_range(0, 3)));
            end else if ($urandom_range(0, 5) == 0) begin
                r = mk(OP_START, $urandom_range(0, 15), $urandom,
                       t_order'($urandom_range(0, 3)));
                if ($urandom_range(0, 9) == 0) r.from_vertex = 6'($urandom);
            end else if ($urandom_range(0, 39) == 0) begin
                r = mk(OP_NONE, $urandom, $urandom, t_order'($urandom_range(0, 3)));
            end else begin
                r = mk(OP_ADD, $urandom_range(0, 15), $urandom_range(0, 15),
                       t_order'($urandom_range(0, 3)));
                if ($urandom_range(0, 7) == 0) begin
                    r.from_vertex = 6'($urandom);
                    r.to_vertex = 6'($urandom);
                end
            end
            send(r, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
            if (k == N_RAND / 2) drain();
            k++;
        end
        drain();
        if (errors == 0 && rsp_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/gte_pkg.sv
rtl/graph_traversal_engine.sv
verif/tb_graph_traversal_engine.sv
